### rtl/assert_macros.svh
// Assertion helpers shared by the queue modules; clk and rst are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold at the same edge as the antecedent.
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/mpq_pkg.sv
package mpq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_PRIORITY_BITS = 8;
  localparam int DEF_PAYLOAD_BITS  = 32;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ZERO  = 2'd3
  } stat_t;

  // Update command broadcast to every cell; each cell decides by its own index.
  typedef struct packed {
    logic shift;  // cells at or above sel_idx take their upper neighbor's entry
    logic load;   // the cell at sel_idx takes the write data
  } cell_op_t;

endpackage

### rtl/min_priority_job_queue.sv
// Job queue of QUEUE_DEPTH slots kept in arrival order in a row of cells. A request carries
// the command in s_tuser and the job in s_tdata. Each request yields one response, with a
// status in m_tuser and the job found plus the counts in m_tdata.
// Enqueue, an unused command and dequeue or peek on an empty queue go from the accept
// straight to S_EXEC, which loads the response into the output register; the next request
// is taken back in S_IDLE. Dequeue and peek on a nonempty queue first pass through S_SCAN,
// where the minimum search walks the cell row one cell per cycle. S_EXEC then loads the
// response and, for a dequeue, shifts all later cells down. One request is in flight at a
// time. A new request is taken while the previous response still waits in the output
// register, but its own response and update stall until that register frees.
module min_priority_job_queue #(
  parameter int QUEUE_DEPTH   = mpq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = mpq_pkg::DEF_PRIORITY_BITS,
  parameter int PAYLOAD_BITS  = mpq_pkg::DEF_PAYLOAD_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // in_priority, in_payload
  input  logic [((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // command
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_priority, out_payload, entry_total, free_slots, is_empty, is_full
  output logic [((PRIORITY_BITS + PAYLOAD_BITS + 2 * $clog2(QUEUE_DEPTH + 1) + 2 + 7) / 8)
                * 8 - 1:0] m_tdata,
  // status
  output logic [1:0] m_tuser
);
  import mpq_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_BITS = PRIORITY_BITS + PAYLOAD_BITS + 2 * CNT_W + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]          count, count_next;
  cmd_t                      cmd_q, in_cmd;
  logic [PRIORITY_BITS-1:0]  pri_q, in_pri, res_pri;
  logic [PAYLOAD_BITS-1:0]   pay_q, in_pay, res_pay;
  stat_t                     res_stat;
  logic                      accept, scan_start, commit, full;
  cell_op_t                  op;
  logic [IDX_W-1:0]          sel_idx;

  logic [PRIORITY_BITS-1:0]  cell_pri [0:QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]   cell_pay [0:QUEUE_DEPTH];
  logic                      scan_valid [0:QUEUE_DEPTH];
  logic                      scan_found [0:QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0]  scan_pri [0:QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]   scan_pay [0:QUEUE_DEPTH];
  logic [IDX_W-1:0]          scan_idx [0:QUEUE_DEPTH];

  assign in_cmd = cmd_t'(s_tuser);
  assign in_pri = s_tdata[PRIORITY_BITS-1:0];
  assign in_pay = s_tdata[PRIORITY_BITS+PAYLOAD_BITS-1:PRIORITY_BITS];

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign scan_start = accept && ((in_cmd == CMD_DEQ) || (in_cmd == CMD_PEEK)) && (count != '0);
  assign commit     = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign full       = (count == CNT_W'(QUEUE_DEPTH));

  // Seed of the search wave, and the empty slot shifted into the top cell.
  assign scan_valid[0]           = scan_start;
  assign scan_found[0]           = 1'b0;
  assign scan_pri[0]             = '0;
  assign scan_pay[0]             = '0;
  assign scan_idx[0]             = '0;
  assign cell_pri[QUEUE_DEPTH]   = '0;
  assign cell_pay[QUEUE_DEPTH]   = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    mpq_cell #(
      .CELL_IDX      (i),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .op             (op),
      .sel_idx        (sel_idx),
      .wr_pri         (pri_q),
      .wr_pay         (pay_q),
      .next_pri       (cell_pri[i+1]),
      .next_pay       (cell_pay[i+1]),
      .pri            (cell_pri[i]),
      .pay            (cell_pay[i]),
      .scan_in_valid  (scan_valid[i]),
      .scan_in_found  (scan_found[i]),
      .scan_in_pri    (scan_pri[i]),
      .scan_in_pay    (scan_pay[i]),
      .scan_in_idx    (scan_idx[i]),
      .scan_out_valid (scan_valid[i+1]),
      .scan_out_found (scan_found[i+1]),
      .scan_out_pri   (scan_pri[i+1]),
      .scan_out_pay   (scan_pay[i+1]),
      .scan_out_idx   (scan_idx[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = scan_start ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (scan_valid[QUEUE_DEPTH]) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outcome of the held request; the cell update fires only on commit.
  always_comb begin
    res_stat   = STAT_OK;
    res_pri    = '0;
    res_pay    = '0;
    count_next = count;
    op         = '0;
    sel_idx    = count[IDX_W-1:0];
    case (cmd_q)
      CMD_ENQ: begin
        if (pri_q == '0) begin
          res_stat = STAT_ZERO;
        end else if (full) begin
          res_stat = STAT_FULL;
        end else begin
          op.load    = commit;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (count == '0) begin
          res_stat = STAT_EMPTY;
        end else begin
          res_pri = scan_pri[QUEUE_DEPTH];
          res_pay = scan_pay[QUEUE_DEPTH];
          if (cmd_q == CMD_DEQ) begin
            op.shift   = commit;
            sel_idx    = scan_idx[QUEUE_DEPTH];
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= in_cmd;
      pri_q <= in_pri;
      pay_q <= in_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser <= res_stat;
      m_tdata <= OUT_W'({(count_next == CNT_W'(QUEUE_DEPTH)),
                         (count_next == '0),
                         CNT_W'(CNT_W'(QUEUE_DEPTH) - count_next),
                         count_next,
                         res_pay,
                         res_pri});
    end
  end

  `ASSERT_ALWAYS(a_count_range, count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `ASSERT_IMPLY(a_scan_in_scan, scan_valid[QUEUE_DEPTH], state == S_SCAN,
                "search finished outside search state")
  `ASSERT_IMPLY(a_scan_found, scan_valid[QUEUE_DEPTH] && (count != '0),
                scan_found[QUEUE_DEPTH], "search found no entry in a nonempty queue")

endmodule

### rtl/mpq_cell.sv
module mpq_cell #(
  parameter int CELL_IDX      = 0,
  parameter int QUEUE_DEPTH   = mpq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = mpq_pkg::DEF_PRIORITY_BITS,
  parameter int PAYLOAD_BITS  = mpq_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mpq_pkg::cell_op_t                op,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   sel_idx,
  input  logic [PRIORITY_BITS-1:0]         wr_pri,
  input  logic [PAYLOAD_BITS-1:0]          wr_pay,
  input  logic [PRIORITY_BITS-1:0]         next_pri,
  input  logic [PAYLOAD_BITS-1:0]          next_pay,
  output logic [PRIORITY_BITS-1:0]         pri,
  output logic [PAYLOAD_BITS-1:0]          pay,
  input  logic                             scan_in_valid,
  input  logic                             scan_in_found,
  input  logic [PRIORITY_BITS-1:0]         scan_in_pri,
  input  logic [PAYLOAD_BITS-1:0]          scan_in_pay,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   scan_in_idx,
  output logic                             scan_out_valid,
  output logic                             scan_out_found,
  output logic [PRIORITY_BITS-1:0]         scan_out_pri,
  output logic [PAYLOAD_BITS-1:0]          scan_out_pay,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   scan_out_idx
);
  import mpq_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic take;

  // A zero priority marks an empty slot; strict compare keeps the earlier entry on a tie.
  assign take = (pri != '0) && (!scan_in_found || (pri < scan_in_pri));

  always_ff @(posedge clk) begin
    if (rst) begin
      pri <= '0;
    end else if (op.shift && (sel_idx <= MY_IDX)) begin
      pri <= next_pri;
    end else if (op.load && (sel_idx == MY_IDX)) begin
      pri <= wr_pri;
    end
  end

  always_ff @(posedge clk) begin
    if (op.shift && (sel_idx <= MY_IDX)) begin
      pay <= next_pay;
    end else if (op.load && (sel_idx == MY_IDX)) begin
      pay <= wr_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out_valid <= 1'b0;
    end else begin
      scan_out_valid <= scan_in_valid;
    end
  end

  // Advance the running minimum one cell per cycle.
  always_ff @(posedge clk) begin
    if (scan_in_valid) begin
      if (take) begin
        scan_out_found <= 1'b1;
        scan_out_pri   <= pri;
        scan_out_pay   <= pay;
        scan_out_idx   <= MY_IDX;
      end else begin
        scan_out_found <= scan_in_found;
        scan_out_pri   <= scan_in_pri;
        scan_out_pay   <= scan_in_pay;
        scan_out_idx   <= scan_in_idx;
      end
    end
  end

  `ASSERT_ALWAYS(a_op_excl, !(op.shift && op.load), "shift and load issued together")
  `ASSERT_ALWAYS(a_packed, !((pri == '0) && (next_pri != '0)), "gap below a stored entry")

endmodule
